// ===== src/ffea_pkg.sv =====
// Shared constants, types and controller/datapath signal groups for the extent allocator.
package ffea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int CW          = $clog2(MAX_EXTENTS + 1);
    localparam int AW          = $clog2(MAX_EXTENTS);
    localparam int DW          = 16;

    localparam logic [DW-1:0] REGION_RESET = 16'd2000;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [DW-1:0] ext_start;
        logic [DW-1:0] ext_end;
    } t_extent;

    typedef struct packed {
        logic start;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic finish;
    } t_stat;

endpackage

// ===== src/ffea_if.sv =====
// Request and response channel interfaces of the extent allocator.
interface ffea_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] release_offset;

    modport source (output valid, kind, request_size, release_offset, input ready);
    modport sink   (input valid, kind, request_size, release_offset, output ready);
endinterface

interface ffea_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

// ===== src/ffea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ffea_ctrl.sv =====
// Controller state machine: request acceptance, table walk sequencing and result hand-off.
module ffea_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ffea_pkg::t_cmd o_cmd,
    input  ffea_pkg::t_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan     = (r_state == S_SCAN);
    assign o_cmd.load_out = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.finish) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/ffea_dp.sv =====
// Datapath: extent table RAM, walk pointer, fit checks, ripple insert and remove, result registers.
module ffea_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffea_pkg::t_cmd              i_cmd,
    output ffea_pkg::t_stat             o_stat,
    input  logic                        i_cfg_we,
    input  logic [ffea_pkg::DW-1:0]     i_cfg_data,
    input  logic                        i_kind,
    input  logic [ffea_pkg::DW-1:0]     i_size,
    input  logic [ffea_pkg::DW-1:0]     i_offset,
    output logic [1:0]                  o_status,
    output logic [ffea_pkg::DW-1:0]     o_granted
);

    logic [ffea_pkg::DW-1:0] r_region;
    logic [ffea_pkg::CW-1:0] r_count, n_count;
    logic [ffea_pkg::CW-1:0] r_j, n_j;
    logic                    r_hit, n_hit;
    logic [ffea_pkg::DW-1:0] r_prev_end, n_prev_end;
    ffea_pkg::t_extent       r_carry, n_carry;
    logic                    r_kind;
    logic [ffea_pkg::DW-1:0] r_size;
    logic [ffea_pkg::DW-1:0] r_offset;
    ffea_pkg::t_status       r_res_status, n_res_status;
    logic [ffea_pkg::DW-1:0] r_res_off, n_res_off;
    ffea_pkg::t_status       r_out_status;
    logic [ffea_pkg::DW-1:0] r_out_off;

    logic                    ram_we;
    logic [ffea_pkg::AW-1:0] ram_wr_addr;
    ffea_pkg::t_extent       ram_wr_data;
    logic [ffea_pkg::AW-1:0] ram_rd_addr;
    ffea_pkg::t_extent       ram_rd_data;

    logic                    at_end;
    logic [ffea_pkg::DW:0]   gap;
    logic                    gap_fits;
    logic [ffea_pkg::DW:0]   last_sum;
    logic                    last_fits;
    logic [ffea_pkg::DW-1:0] new_start;
    ffea_pkg::t_extent       new_ext;
    logic                    finish;
    logic [ffea_pkg::CW-1:0] j_inc;
    logic [ffea_pkg::CW-1:0] j_dec;

    ffea_ram #(
        .WIDTH ($bits(ffea_pkg::t_extent)),
        .DEPTH (ffea_pkg::MAX_EXTENTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign j_inc       = r_j + ffea_pkg::CW'(1);
    assign j_dec       = r_j - ffea_pkg::CW'(1);
    assign ram_rd_addr = i_cmd.scan ? j_inc[ffea_pkg::AW-1:0] : '0;

    assign at_end    = (r_j == r_count);
    assign gap       = {1'b0, ram_rd_data.ext_start} - {1'b0, r_prev_end};
    assign gap_fits  = !gap[ffea_pkg::DW] && (gap[ffea_pkg::DW-1:0] > r_size);
    assign last_sum  = {1'b0, r_prev_end} + {1'b0, r_size};
    assign last_fits = last_sum < {1'b0, r_region};
    assign new_start = r_prev_end + ffea_pkg::DW'(1);
    assign new_ext   = '{ext_start: new_start, ext_end: last_sum[ffea_pkg::DW-1:0]};

    always_comb begin
        n_count      = r_count;
        n_j          = r_j;
        n_hit        = r_hit;
        n_prev_end   = r_prev_end;
        n_carry      = r_carry;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        ram_we       = 1'b0;
        ram_wr_addr  = r_j[ffea_pkg::AW-1:0];
        ram_wr_data  = r_carry;
        finish       = 1'b0;

        if (i_cmd.start) begin
            n_j        = '0;
            n_hit      = 1'b0;
            n_prev_end = '0;
        end else if (i_cmd.scan) begin
            n_j = j_inc;
            if (r_kind == ffea_pkg::KIND_ALLOC) begin
                if (r_size == '0) begin
                    finish       = 1'b1;
                    n_res_status = ffea_pkg::ST_NO_SPACE;
                    n_res_off    = '0;
                end else if (r_count == ffea_pkg::CW'(ffea_pkg::MAX_EXTENTS)) begin
                    finish       = 1'b1;
                    n_res_status = ffea_pkg::ST_FULL;
                    n_res_off    = '0;
                end else if (!r_hit) begin
                    if (!at_end) begin
                        if ((r_j != '0) && gap_fits) begin
                            ram_we      = 1'b1;
                            ram_wr_data = new_ext;
                            n_carry     = ram_rd_data;
                            n_hit       = 1'b1;
                            n_res_off   = new_start;
                        end else begin
                            n_prev_end = ram_rd_data.ext_end;
                        end
                    end else if (last_fits) begin
                        ram_we       = 1'b1;
                        ram_wr_data  = new_ext;
                        n_count      = r_count + ffea_pkg::CW'(1);
                        finish       = 1'b1;
                        n_res_status = ffea_pkg::ST_OK;
                        n_res_off    = new_start;
                    end else begin
                        finish       = 1'b1;
                        n_res_status = ffea_pkg::ST_NO_SPACE;
                        n_res_off    = '0;
                    end
                end else begin
                    ram_we = 1'b1;
                    if (!at_end) begin
                        n_carry = ram_rd_data;
                    end else begin
                        n_count      = r_count + ffea_pkg::CW'(1);
                        finish       = 1'b1;
                        n_res_status = ffea_pkg::ST_OK;
                    end
                end
            end else begin
                if (!r_hit) begin
                    if (at_end || (ram_rd_data.ext_start > r_offset)) begin
                        finish       = 1'b1;
                        n_res_status = ffea_pkg::ST_NOT_FOUND;
                        n_res_off    = '0;
                    end else if (ram_rd_data.ext_start == r_offset) begin
                        n_hit = 1'b1;
                    end
                end else if (!at_end) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = j_dec[ffea_pkg::AW-1:0];
                    ram_wr_data = ram_rd_data;
                end else begin
                    n_count      = r_count - ffea_pkg::CW'(1);
                    finish       = 1'b1;
                    n_res_status = ffea_pkg::ST_OK;
                    n_res_off    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= ffea_pkg::REGION_RESET;
            r_count  <= '0;
            r_hit    <= 1'b0;
            r_j      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_data;
            end
            r_count <= n_count;
            r_hit   <= n_hit;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_end   <= n_prev_end;
        r_carry      <= n_carry;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        if (i_cmd.start) begin
            r_kind   <= i_kind;
            r_size   <= i_size;
            r_offset <= i_offset;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
        end
    end

    assign o_stat.finish = finish;
    assign o_status      = r_out_status;
    assign o_granted     = r_out_off;

endmodule

// ===== src/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: controller and datapath joined by command and status.
// One request is in work at a time. A request walks the table one entry per cycle, and a request
// that is rejected up front ends at the first walk step; the result then moves to the output
// register once that register is free, and a new request is taken as soon as the previous result
// sits in the output register. Synchronous reset empties the table and sets region_size to 2000.
module first_fit_extent_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    ffea_req_if.sink    i_req,
    ffea_rsp_if.source  o_rsp
);

    ffea_pkg::t_cmd  cmd;
    ffea_pkg::t_stat stat;

    ffea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ffea_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_req.kind),
        .i_size     (i_req.request_size),
        .i_offset   (i_req.release_offset),
        .o_status   (o_rsp.status),
        .o_granted  (o_rsp.granted_offset)
    );

endmodule

// ===== src/ffea_checker.sv =====
// Port-level assertions for the extent allocator and the bind that attaches them.
module ffea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [15:0] i_rsp_granted
);

    // A waiting result beat is held until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    // Only one request is in work: ready drops after every accepted beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted while one is in work");

    // Failed requests never grant an offset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ffea_pkg::ST_OK) |-> (i_rsp_granted == 16'd0))
        else $error("nonzero offset on a failed request");

    // No result beat is valid straight after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response beat valid straight after reset");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_granted (o_rsp.granted_offset)
);
